FILE: rtl/srfw_pkg.sv
// ----------------------------------------------------------------------------
// srfw_pkg: shared types and constants of the stream receive flow window
// item layouts, opcodes, register map and configuration bundle
// ----------------------------------------------------------------------------
package srfw_pkg;

  // offset width of received and read offsets
  localparam int OFFSET_BITS = 62;
  localparam int LIMIT_BITS  = 64;
  localparam int TIME_BITS   = 64;
  localparam int WIN_BITS    = 32;
  localparam int RTT_BITS    = 32;

  // apb register map
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_INITIAL_WINDOW    = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_CAP        = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_CONN_LIMIT_ENABLE = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_CONN_WINDOW_LIMIT = 2'd3;

  // register reset values
  localparam logic [WIN_BITS-1:0] INITIAL_WINDOW_RST    = 32'd65536;
  localparam logic [WIN_BITS-1:0] WINDOW_CAP_RST        = 32'd16777216;
  localparam logic                CONN_LIMIT_ENABLE_RST = 1'b1;
  localparam logic [WIN_BITS-1:0] CONN_WINDOW_LIMIT_RST = 32'd16777216;

  // opcodes
  localparam logic [1:0] OP_INIT          = 2'd0;
  localparam logic [1:0] OP_DATA_RECEIVED = 2'd1;
  localparam logic [1:0] OP_READ_ADVANCED = 2'd2;
  localparam logic [1:0] OP_UPDATE_CHECK  = 2'd3;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [OFFSET_BITS-1:0] offset;
    logic [TIME_BITS-1:0]   now_time;
    logic [RTT_BITS-1:0]    smoothed_rtt;
    logic                   conn_grant;
  } in_item_t;

  typedef struct packed {
    logic                   accepted;
    logic                   violation;
    logic [LIMIT_BITS-1:0]  advertised_limit;
    logic [WIN_BITS-1:0]    window_size;
    logic [OFFSET_BITS-1:0] conn_increment;
  } out_item_t;

  typedef struct packed {
    logic [WIN_BITS-1:0] initial_window;
    logic [WIN_BITS-1:0] window_cap;
    logic                conn_limit_enable;
    logic [WIN_BITS-1:0] conn_window_limit;
  } cfg_t;

endpackage

FILE: rtl/srfw_cfg.sv
// ----------------------------------------------------------------------------
// srfw_cfg: configuration registers
// apb write and read access to the four window control registers
// ----------------------------------------------------------------------------
module srfw_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srfw_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [srfw_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [srfw_pkg::APB_DATA_BITS-1:0]   prdata,
  output srfw_pkg::cfg_t                       cfg
);

  logic                                wr;
  logic [srfw_pkg::REG_IDX_BITS-1:0]   idx;

  assign idx = paddr[srfw_pkg::APB_ADDR_BITS-1:2];
  assign wr  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_window    <= srfw_pkg::INITIAL_WINDOW_RST;
      cfg.window_cap        <= srfw_pkg::WINDOW_CAP_RST;
      cfg.conn_limit_enable <= srfw_pkg::CONN_LIMIT_ENABLE_RST;
      cfg.conn_window_limit <= srfw_pkg::CONN_WINDOW_LIMIT_RST;
    end else if (wr) begin
      case (idx)
        srfw_pkg::REG_INITIAL_WINDOW:    cfg.initial_window    <= pwdata;
        srfw_pkg::REG_WINDOW_CAP:        cfg.window_cap        <= pwdata;
        srfw_pkg::REG_CONN_LIMIT_ENABLE: cfg.conn_limit_enable <= pwdata[0];
        srfw_pkg::REG_CONN_WINDOW_LIMIT: cfg.conn_window_limit <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      srfw_pkg::REG_INITIAL_WINDOW:    prdata = cfg.initial_window;
      srfw_pkg::REG_WINDOW_CAP:        prdata = cfg.window_cap;
      srfw_pkg::REG_CONN_LIMIT_ENABLE:
        prdata = {{(srfw_pkg::APB_DATA_BITS-1){1'b0}}, cfg.conn_limit_enable};
      srfw_pkg::REG_CONN_WINDOW_LIMIT: prdata = cfg.conn_window_limit;
      default:                         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/srfw_core.sv
// ----------------------------------------------------------------------------
// srfw_core: flow window state and update logic
// holds limit, offsets, window and last update time; one item per step
// ----------------------------------------------------------------------------
module srfw_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  srfw_pkg::in_item_t   item,
  input  srfw_pkg::cfg_t       cfg,
  output srfw_pkg::out_item_t  res
);

  localparam int OB = srfw_pkg::OFFSET_BITS;
  localparam int LB = srfw_pkg::LIMIT_BITS;
  localparam int TB = srfw_pkg::TIME_BITS;
  localparam int WB = srfw_pkg::WIN_BITS;

  // state
  logic [LB-1:0] limit_offset,     limit_offset_next;
  logic [OB-1:0] consumed_offset,  consumed_offset_next;
  logic [OB-1:0] highest_received, highest_received_next;
  logic [WB-1:0] window_now,       window_now_next;
  logic [TB-1:0] last_update_time, last_update_time_next;

  // limit move inputs, forced to the cleared state on init
  logic          is_init;
  logic [LB-1:0] base_limit;
  logic [LB-1:0] base_consumed;
  logic [TB-1:0] base_last;
  logic [WB-1:0] base_window;

  logic [LB-1:0] room;
  logic          move;
  logic [TB-1:0] elapsed;
  logic          fast;
  logic [WB:0]   cand_dbl;
  logic [WB:0]   cand_cap;
  logic [WB:0]   cand_conn;
  logic [WB-1:0] grown;
  logic [LB-1:0] moved_limit;
  logic [LB-1:0] off_wide;

  assign is_init       = (item.opcode == srfw_pkg::OP_INIT);
  assign base_limit    = is_init ? '0 : limit_offset;
  assign base_consumed = is_init ? '0 : LB'(consumed_offset);
  assign base_last     = is_init ? '0 : last_update_time;
  assign base_window   = is_init ? cfg.initial_window : window_now;

  // remaining room against half a window
  assign room = (base_limit > base_consumed) ? (base_limit - base_consumed) : '0;
  assign move = (room < LB'(base_window >> 1));

  // autotune: double when the previous move is within two rtts
  assign elapsed   = item.now_time - base_last;
  assign fast      = (elapsed < TB'({item.smoothed_rtt, 1'b0}));
  assign cand_dbl  = {base_window, 1'b0};
  assign cand_cap  = (cand_dbl > {1'b0, cfg.window_cap}) ? {1'b0, cfg.window_cap} : cand_dbl;
  assign cand_conn = (cfg.conn_limit_enable && (cand_cap > {1'b0, cfg.conn_window_limit})) ?
                     {1'b0, cfg.conn_window_limit} : cand_cap;
  assign grown     = (fast && (cand_conn > {1'b0, base_window})) ? cand_conn[WB-1:0] :
                     base_window;
  assign moved_limit = base_consumed + LB'(grown);
  assign off_wide    = LB'(item.offset);

  // next state and result
  always_comb begin
    limit_offset_next     = limit_offset;
    consumed_offset_next  = consumed_offset;
    highest_received_next = highest_received;
    window_now_next       = window_now;
    last_update_time_next = last_update_time;
    res.accepted          = 1'b0;
    res.violation         = 1'b0;
    res.conn_increment    = '0;
    case (item.opcode)
      srfw_pkg::OP_INIT: begin
        consumed_offset_next  = '0;
        highest_received_next = '0;
        limit_offset_next     = move ? moved_limit : '0;
        window_now_next       = move ? grown : cfg.initial_window;
        last_update_time_next = move ? item.now_time : '0;
        res.accepted          = move;
      end
      srfw_pkg::OP_DATA_RECEIVED: begin
        if (off_wide <= limit_offset) begin
          if (cfg.conn_limit_enable && (item.offset > highest_received)) begin
            res.conn_increment = item.offset - highest_received;
          end
          if (!cfg.conn_limit_enable || item.conn_grant) begin
            highest_received_next = item.offset;
            res.accepted          = 1'b1;
          end
        end else begin
          res.violation = 1'b1;
        end
      end
      srfw_pkg::OP_READ_ADVANCED: begin
        if (cfg.conn_limit_enable && (item.offset > consumed_offset)) begin
          res.conn_increment = item.offset - consumed_offset;
        end
        consumed_offset_next = item.offset;
      end
      srfw_pkg::OP_UPDATE_CHECK: begin
        if (move) begin
          limit_offset_next     = moved_limit;
          window_now_next       = grown;
          last_update_time_next = item.now_time;
        end
        res.accepted = move;
      end
      default: begin
      end
    endcase
    res.advertised_limit = limit_offset_next;
    res.window_size      = window_now_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_offset     <= '0;
      consumed_offset  <= '0;
      highest_received <= '0;
      window_now       <= '0;
      last_update_time <= '0;
    end else if (step) begin
      limit_offset     <= limit_offset_next;
      consumed_offset  <= consumed_offset_next;
      highest_received <= highest_received_next;
      window_now       <= window_now_next;
      last_update_time <= last_update_time_next;
    end
  end

endmodule

FILE: rtl/stream_receive_flow_window.sv
// ----------------------------------------------------------------------------
// stream_receive_flow_window: receive flow-control window of one stream
// path: input register, limit and window update, then the result register
// throughput: one item per cycle unless the receiver stalls the result register
// reset clears the window state and loads the register defaults
// ----------------------------------------------------------------------------
module stream_receive_flow_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  srfw_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output srfw_pkg::out_item_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srfw_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [srfw_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [srfw_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  srfw_pkg::cfg_t      cfg;
  srfw_pkg::in_item_t  stage;
  logic                stage_valid;
  srfw_pkg::out_item_t res;
  logic                step;

  assign pready = 1'b1;

  srfw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // the staged item is processed whenever the result register is free
  assign step     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  srfw_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (stage),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  // a staged item with a free result register always produces a result
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_valid) |=> out_valid)
    else $error("staged item not processed");

  // a violation never reports an increment or acceptance
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.violation) |->
      (out_data.conn_increment == '0) && !out_data.accepted)
    else $error("violation with increment or acceptance");

  // read_advanced never accepts and never flags a violation
  assert property (@(posedge clk) disable iff (rst)
    (step && (stage.opcode == srfw_pkg::OP_READ_ADVANCED)) |=>
      (!out_data.accepted && !out_data.violation))
    else $error("read item flagged as accepted");

  // without a connection controller no increment is reported
  assert property (@(posedge clk) disable iff (rst)
    (step && !cfg.conn_limit_enable) |=> (out_data.conn_increment == '0))
    else $error("increment without connection controller");
`endif

endmodule

FILE: verif/srfw_tb_pkg.sv
// ----------------------------------------------------------------------------
// srfw_tb_pkg: scoreboard for the stream receive flow window
// keeps its own copy of the registers and window state, works out the result
// of every accepted item and checks the results in order, field by field
// ----------------------------------------------------------------------------
package srfw_tb_pkg;
  import srfw_pkg::*;

  class flow_scoreboard;
    // register copies
    bit [WIN_BITS-1:0]    init_win;
    bit [WIN_BITS-1:0]    win_cap;
    bit                   conn_en;
    bit [WIN_BITS-1:0]    conn_win;
    // window state
    bit [LIMIT_BITS-1:0]  limit_off;
    bit [OFFSET_BITS-1:0] consumed_off;
    bit [OFFSET_BITS-1:0] high_off;
    bit [WIN_BITS-1:0]    win;
    bit [TIME_BITS-1:0]   last_move;
    // results still owed by the block, oldest first
    out_item_t            owed_results[$];
    int unsigned          errors;

    function new();
      init_win     = INITIAL_WINDOW_RST;
      win_cap      = WINDOW_CAP_RST;
      conn_en      = CONN_LIMIT_ENABLE_RST;
      conn_win     = CONN_WINDOW_LIMIT_RST;
      limit_off    = '0;
      consumed_off = '0;
      high_off     = '0;
      win          = '0;
      last_move    = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
      case (idx)
        REG_INITIAL_WINDOW:    init_win = value;
        REG_WINDOW_CAP:        win_cap  = value;
        REG_CONN_LIMIT_ENABLE: conn_en  = value[0];
        REG_CONN_WINDOW_LIMIT: conn_win = value;
        default: ;
      endcase
    endfunction

    // re-advertise once less than half a window is left, doubling on fast updates
    function bit try_move_limit(bit [TIME_BITS-1:0] now, bit [RTT_BITS-1:0] rtt);
      bit [63:0] read_wide;
      bit [63:0] room;
      bit [63:0] half;
      bit [63:0] elapsed;
      bit [63:0] twice_rtt;
      bit [63:0] grown;
      read_wide = 64'(consumed_off);
      room = (limit_off > read_wide) ? limit_off - read_wide : 64'd0;
      half = {33'd0, win[WIN_BITS-1:1]};
      if (room >= half) return 1'b0;
      elapsed   = now - last_move;
      last_move = now;
      twice_rtt = 64'(rtt);
      twice_rtt = twice_rtt << 1;
      if (elapsed < twice_rtt) begin
        // doubled in 64 bits, so no wrap
        grown = 64'(win);
        grown = grown << 1;
        if (grown > {32'd0, win_cap}) grown = {32'd0, win_cap};
        if (conn_en && grown > {32'd0, conn_win}) grown = {32'd0, conn_win};
        if (grown > {32'd0, win}) win = grown[WIN_BITS-1:0];
      end
      limit_off = read_wide + {32'd0, win};
      return 1'b1;
    endfunction

    // accepted input item: update state and queue the result it owes
    function void note_event(in_item_t it);
      out_item_t            r;
      bit [OFFSET_BITS-1:0] off;
      bit [63:0]            off_wide;
      r        = '0;
      off      = it.offset;
      off_wide = 64'(off);
      case (it.opcode)
        OP_INIT: begin
          win          = init_win;
          limit_off    = '0;
          consumed_off = '0;
          high_off     = '0;
          last_move    = '0;
          r.accepted = try_move_limit(it.now_time, it.smoothed_rtt);
        end
        OP_DATA_RECEIVED: begin
          if (off_wide <= limit_off) begin
            // increment is reported even when the grant is refused
            if (conn_en) r.conn_increment = (off > high_off) ? off - high_off : '0;
            if (!conn_en || it.conn_grant) begin
              high_off   = off;
              r.accepted = 1'b1;
            end
          end else begin
            r.violation = 1'b1;
          end
        end
        OP_READ_ADVANCED: begin
          if (conn_en) r.conn_increment = (off > consumed_off) ? off - consumed_off : '0;
          consumed_off = off;
        end
        default: r.accepted = try_move_limit(it.now_time, it.smoothed_rtt);
      endcase
      r.advertised_limit = limit_off;
      r.window_size      = win;
      owed_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // accepted result item against the oldest owed one
    task check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with no item pending, limit %0h", got.advertised_limit));
        return;
      end
      want = owed_results.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
      if (got.violation !== want.violation)
        report($sformatf("violation %0b, want %0b", got.violation, want.violation));
      if (got.advertised_limit !== want.advertised_limit)
        report($sformatf("advertised_limit %0h, want %0h", got.advertised_limit,
                         want.advertised_limit));
      if (got.window_size !== want.window_size)
        report($sformatf("window_size %0h, want %0h", got.window_size, want.window_size));
      if (got.conn_increment !== want.conn_increment)
        report($sformatf("conn_increment %0h, want %0h", got.conn_increment,
                         want.conn_increment));
    endtask
  endclass

endpackage

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the stream receive flow window
// directed items over the corner cases, then random items shaped around the
// live window state under several register settings, with random gaps and
// receiver stalls; every result is checked by the scoreboard
// ----------------------------------------------------------------------------
module tb_top;
  import srfw_pkg::*;
  import srfw_tb_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [TIME_BITS-1:0]   TIME_MAX = '1;
  localparam logic [RTT_BITS-1:0]    RTT_MAX  = '1;
  localparam logic [WIN_BITS-1:0]    WIN_MAX  = '1;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  in_item_t                 in_data    = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  out_item_t                out_data;
  logic                     psel       = 1'b0;
  logic                     penable    = 1'b0;
  logic                     pwrite     = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr      = '0;
  logic [APB_DATA_BITS-1:0] pwdata     = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  flow_scoreboard sb;
  logic           quiet_tail = 1'b0;
  int unsigned    stall_left = 0;

  always #5 clk = ~clk;

  stream_receive_flow_window dut (.*);

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  // registers change only once the block has drained
  task automatic configure(logic [31:0] iw, logic [31:0] cap, logic en, logic [31:0] cwl);
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_INITIAL_WINDOW, iw);
    write_reg(REG_WINDOW_CAP, cap);
    write_reg(REG_CONN_LIMIT_ENABLE, {31'd0, en});
    write_reg(REG_CONN_WINDOW_LIMIT, cwl);
  endtask

  task automatic send_item(in_item_t it);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(it);
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [OFFSET_BITS-1:0] off,
                                         logic [TIME_BITS-1:0] now,
                                         logic [RTT_BITS-1:0] rtt, logic grant);
    in_item_t it;
    it.opcode       = op;
    it.offset       = off;
    it.now_time     = now;
    it.smoothed_rtt = rtt;
    it.conn_grant   = grant;
    return it;
  endfunction

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return WIN_MAX;
      2: return $urandom_range(2, 300);
      3: return $urandom_range(1000, 100000);
      default: return $urandom;
    endcase
  endfunction

  // random item, mostly placed around the current window state
  function automatic in_item_t pick_item();
    in_item_t    it;
    logic [63:0] base;
    logic [63:0] twice_rtt;
    int unsigned pick;
    base            = {$urandom, $urandom};
    it.opcode       = OP_UPDATE_CHECK;
    it.offset       = base[OFFSET_BITS-1:0];
    it.now_time     = {$urandom, $urandom};
    it.smoothed_rtt = $urandom;
    it.conn_grant   = ($urandom_range(0, 3) != 0);
    pick            = $urandom_range(0, 99);
    if (pick < 4) begin
      it.opcode = OP_INIT;
      if ($urandom_range(0, 1) != 0) begin
        it.now_time     = 64'($urandom_range(0, 5000));
        it.smoothed_rtt = $urandom_range(0, 3000);
      end
    end else if (pick < 42) begin
      it.opcode = OP_DATA_RECEIVED;
      case ($urandom_range(0, 6))
        0, 1: base = 64'(sb.high_off) + 64'($urandom_range(0, sb.win));
        2: base = sb.limit_off;
        3: base = sb.limit_off + 64'd1;
        4: base = sb.limit_off - 64'($urandom_range(1, 3));
        5: base = 64'(sb.high_off) - 64'($urandom_range(0, 1000));
        default: ;
      endcase
      it.offset = base[OFFSET_BITS-1:0];
    end else if (pick < 70) begin
      it.opcode = OP_READ_ADVANCED;
      case ($urandom_range(0, 5))
        0, 1: base = 64'(sb.consumed_off) + 64'($urandom_range(0, sb.win));
        2: base = 64'(sb.consumed_off) + {33'd0, sb.win[WIN_BITS-1:1]} +
                  64'($urandom_range(0, 2));
        3: base = sb.limit_off + 64'($urandom_range(0, 100));
        4: base = 64'(sb.consumed_off) - 64'($urandom_range(0, 1000));
        default: ;
      endcase
      it.offset = base[OFFSET_BITS-1:0];
    end else begin
      // update time placed around the two-rtt boundary
      if ($urandom_range(0, 4) != 0) it.smoothed_rtt = $urandom_range(0, 3000);
      twice_rtt = 64'(it.smoothed_rtt);
      twice_rtt = twice_rtt << 1;
      case ($urandom_range(0, 5))
        0, 1: it.now_time = sb.last_move + ({32'd0, $urandom} % (twice_rtt + 64'd1));
        2: it.now_time = sb.last_move + twice_rtt - 64'd1;
        3: it.now_time = sb.last_move + twice_rtt;
        4: it.now_time = sb.last_move + twice_rtt + 64'($urandom_range(1, 100000));
        default: ;
      endcase
    end
    return it;
  endfunction

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: basic window, grants, violation, reads, doubling, time wrap
    configure(32'd65536, 32'd16777216, 1'b1, 32'd16777216);
    send_item(make_item(OP_INIT, '0, 64'd1000, 32'd100, 1'b1));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd1050, 32'd100, 1'b1));
    send_item(make_item(OP_DATA_RECEIVED, 62'd1000, '0, '0, 1'b1));
    send_item(make_item(OP_DATA_RECEIVED, 62'd2000, '0, '0, 1'b0));
    send_item(make_item(OP_DATA_RECEIVED, 62'd65536, '0, '0, 1'b1));
    send_item(make_item(OP_DATA_RECEIVED, 62'd65537, '0, '0, 1'b1));
    send_item(make_item(OP_DATA_RECEIVED, 62'd500, '0, '0, 1'b1));
    send_item(make_item(OP_READ_ADVANCED, 62'd50000, '0, '0, 1'b0));
    send_item(make_item(OP_READ_ADVANCED, 62'd40000, '0, '0, 1'b0));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd1100, 32'd100, 1'b0));
    send_item(make_item(OP_READ_ADVANCED, OFF_MAX, '0, '0, 1'b1));
    send_item(make_item(OP_UPDATE_CHECK, OFF_MAX, TIME_MAX, RTT_MAX, 1'b0));
    send_item(make_item(OP_DATA_RECEIVED, OFF_MAX, TIME_MAX, RTT_MAX, 1'b1));
    send_item(make_item(OP_INIT, '0, 64'hFFFF_FFFF_FFFF_FFF0, RTT_MAX, 1'b0));
    send_item(make_item(OP_READ_ADVANCED, 62'd65536, '0, '0, 1'b0));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd4, 32'd100, 1'b0));
    send_item(make_item(OP_INIT, '0, '0, '0, 1'b0));

    // directed: no connection controller, grant ignored and no increments
    configure(32'd1000, WIN_MAX, 1'b0, 32'd0);
    send_item(make_item(OP_INIT, '0, 64'd0, 32'd5, 1'b0));
    send_item(make_item(OP_DATA_RECEIVED, 62'd1500, '0, '0, 1'b0));
    send_item(make_item(OP_READ_ADVANCED, 62'd1500, '0, '0, 1'b0));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd7, 32'd5, 1'b0));

    // directed: tiny window never moves the limit
    configure(32'd1, 32'd8, 1'b1, 32'd4);
    send_item(make_item(OP_INIT, '0, 64'd0, 32'd100, 1'b1));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd1, 32'd100, 1'b1));

    // directed: doubling past 32 bits, capped by the connection window
    configure(32'h8000_0000, WIN_MAX, 1'b1, 32'hC000_0000);
    send_item(make_item(OP_INIT, '0, 64'd0, 32'd1, 1'b1));
    send_item(make_item(OP_UPDATE_CHECK, '0, 64'd1, 32'd1, 1'b1));

    // random phases, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) configure('0, '0, 1'b1, '0);
      else if (ph == 1) configure(WIN_MAX, WIN_MAX, 1'b1, WIN_MAX);
      else configure(pick_reg_value(), pick_reg_value(), 1'($urandom_range(0, 1)),
                     pick_reg_value());
      quiet_tail = (ph == 7);
      send_item(make_item(OP_INIT, '0, 64'($urandom_range(0, 5000)),
                          $urandom_range(0, 3000), 1'b1));
      for (int n = 0; n < 180; n++) send_item(pick_item());
    end

    // drain
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
